FILE: hdl/fhc_pkg.sv
// Package for the fire heat column block.
// Holds the channel payload types, the palette type, register codes and reset values.
// No dependencies.
`default_nettype none

package fhc_pkg;

    localparam int HEIGHT     = 8;
    localparam int CELL_W     = 8;
    localparam int COOL_W     = 7;
    localparam int COLOR_W    = 24;
    localparam int COL_IN_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef logic [CELL_W-1:0]  t_heat;
    typedef t_heat [HEIGHT-1:0] t_heat_col;
    typedef logic [COLOR_W-1:0] t_color;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOT_THR   = 3'd0,
        CFG_WARM_THR  = 3'd1,
        CFG_EMBER_THR = 3'd2,
        CFG_HOT_COL   = 3'd3,
        CFG_WARM_COL  = 3'd4,
        CFG_EMBER_COL = 3'd5
    } t_cfg_idx;

    localparam t_heat  RST_HOT_THR   = 8'd180;
    localparam t_heat  RST_WARM_THR  = 8'd120;
    localparam t_heat  RST_EMBER_THR = 8'd60;
    localparam t_color RST_HOT_COL   = 24'hFF5000;
    localparam t_color RST_WARM_COL  = 24'hC81E00;
    localparam t_color RST_EMBER_COL = 24'h780A00;
    localparam t_color BLACK         = 24'h000000;

    typedef struct packed {
        t_heat  thr_hot;
        t_heat  thr_warm;
        t_heat  thr_ember;
        t_color col_hot;
        t_color col_warm;
        t_color col_ember;
    } t_palette;

    typedef struct packed {
        logic [COL_IN_W-1:0] column;
        logic [COOL_W-1:0]   cool_0;
        logic [COOL_W-1:0]   cool_1;
        logic [COOL_W-1:0]   cool_2;
        logic [COOL_W-1:0]   cool_3;
        logic [COOL_W-1:0]   cool_4;
        logic [COOL_W-1:0]   cool_5;
        logic [COOL_W-1:0]   cool_6;
        logic [COOL_W-1:0]   cool_7;
        logic                spark;
        t_heat               spark_heat;
    } t_in_item;

    typedef struct packed {
        logic [COL_IN_W-1:0] out_column;
        t_color              pixel_row0;
        t_color              pixel_row1;
        t_color              pixel_row2;
        t_color              pixel_row3;
        t_color              pixel_row4;
        t_color              pixel_row5;
        t_color              pixel_row6;
        t_color              pixel_row7;
    } t_out_item;

endpackage

`default_nettype wire

FILE: hdl/fhc_in_if.sv
// Input channel of the fire heat column block: valid, ready and one update transaction.
// Depends on fhc_pkg.
`default_nettype none

interface fhc_in_if;
    logic              valid;
    logic              ready;
    fhc_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/fhc_out_if.sv
// Output channel of the fire heat column block: valid, ready and one pixel column transaction.
// Depends on fhc_pkg.
`default_nettype none

interface fhc_out_if;
    logic               valid;
    logic               ready;
    fhc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/led_fire_heat_column.sv
// Top level of the fire heat column block: column heat store, cool and rise update, shading.
// Depends on fhc_pkg, fhc_in_if, fhc_out_if and fhc_shade.
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+-------------
//  i_in     | in  | column, cool_0..cool_7, spark, spark_heat | valid/ready
//  o_out    | out | out_column, pixel_row0..pixel_row7        | valid/ready
//  cfg      | in  | i_cfg_idx, i_cfg_data                     | i_cfg_we
//
// One transaction per cycle while the output is not stalled; an accepted transaction passes
// through the stage 1, stage 2 and stage 3 registers before it is offered on the output.
// Stage 1 reads the column word, stage 2 cools, lifts and writes back, stage 3 shades.
// A write-first bypass on the column store lets back-to-back updates of one column chain.
// Reset clears one valid bit per column; an unwritten column reads as all zero heat.
// Output stalls back up through the stage enables; nothing is dropped or repeated.
`default_nettype none

module led_fire_heat_column #(
    parameter int COLUMNS = 8
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    fhc_in_if.sink                                i_in,
    fhc_out_if.source                             o_out,
    input  wire                                   i_cfg_we,
    input  wire  [fhc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire  [fhc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int COL_CODES = 1 << fhc_pkg::COL_IN_W;

    fhc_pkg::t_palette r_pal;

    logic [fhc_pkg::COL_IN_W-1:0] col_tab [COL_CODES];

    logic                         s1_en;
    logic                         s2_en;
    logic                         s3_en;
    logic                         wr_en;
    logic [COL_W-1:0]             wr_addr;
    logic [COL_W-1:0]             rd_addr;
    logic [fhc_pkg::COL_IN_W-1:0] in_col;

    logic                         r_s1_v;
    fhc_pkg::t_in_item            r_s1_item;
    logic [fhc_pkg::COL_IN_W-1:0] r_s1_col;
    fhc_pkg::t_heat_col           r_rd_heat;
    logic                         r_rd_ok;

    logic                         r_s2_v;
    logic [fhc_pkg::COL_IN_W-1:0] r_s2_col;
    fhc_pkg::t_heat_col           r_s2_heat;

    logic                         r_s3_v;
    fhc_pkg::t_out_item           r_s3_out;

    fhc_pkg::t_heat_col           r_mem [COLUMNS];
    logic [COLUMNS-1:0]           r_vld;

    fhc_pkg::t_heat_col           cur_heat;
    fhc_pkg::t_heat_col           cooled;
    fhc_pkg::t_heat_col           n_heat;
    logic [fhc_pkg::COOL_W-1:0]   cool [fhc_pkg::HEIGHT];
    fhc_pkg::t_color              color [fhc_pkg::HEIGHT];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal.thr_hot   <= fhc_pkg::RST_HOT_THR;
            r_pal.thr_warm  <= fhc_pkg::RST_WARM_THR;
            r_pal.thr_ember <= fhc_pkg::RST_EMBER_THR;
            r_pal.col_hot   <= fhc_pkg::RST_HOT_COL;
            r_pal.col_warm  <= fhc_pkg::RST_WARM_COL;
            r_pal.col_ember <= fhc_pkg::RST_EMBER_COL;
        end else if (i_cfg_we) begin
            unique case (fhc_pkg::t_cfg_idx'(i_cfg_idx))
                fhc_pkg::CFG_HOT_THR:   r_pal.thr_hot   <= i_cfg_data[fhc_pkg::CELL_W-1:0];
                fhc_pkg::CFG_WARM_THR:  r_pal.thr_warm  <= i_cfg_data[fhc_pkg::CELL_W-1:0];
                fhc_pkg::CFG_EMBER_THR: r_pal.thr_ember <= i_cfg_data[fhc_pkg::CELL_W-1:0];
                fhc_pkg::CFG_HOT_COL:   r_pal.col_hot   <= i_cfg_data[fhc_pkg::COLOR_W-1:0];
                fhc_pkg::CFG_WARM_COL:  r_pal.col_warm  <= i_cfg_data[fhc_pkg::COLOR_W-1:0];
                fhc_pkg::CFG_EMBER_COL: r_pal.col_ember <= i_cfg_data[fhc_pkg::COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // fold the column code into range
    for (genvar g = 0; g < COL_CODES; g++) begin : g_col_tab
        assign col_tab[g] = fhc_pkg::COL_IN_W'(g % COLUMNS);
    end

    assign in_col  = col_tab[i_in.data.column];
    assign rd_addr = COL_W'(in_col);
    assign wr_addr = COL_W'(r_s1_col);

    assign s3_en      = !r_s3_v || o_out.ready;
    assign s2_en      = !r_s2_v || s3_en;
    assign s1_en      = !r_s1_v || s2_en;
    assign wr_en      = r_s1_v && s2_en;
    assign i_in.ready = s1_en;

    // stage 1: capture transaction and read column word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_rd_ok <= 1'b0;
            r_vld   <= '0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (s1_en) begin
                r_s1_v  <= i_in.valid;
                r_rd_ok <= (wr_en && wr_addr == rd_addr) || r_vld[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= n_heat;
        end
        if (s1_en) begin
            r_s1_item <= i_in.data;
            r_s1_col  <= in_col;
            if (wr_en && wr_addr == rd_addr) begin
                r_rd_heat <= n_heat;
            end else begin
                r_rd_heat <= r_mem[rd_addr];
            end
        end
    end

    // stage 2: cool, lift, spark
    assign cur_heat = r_rd_ok ? r_rd_heat : '0;
    assign cool[0]  = r_s1_item.cool_0;
    assign cool[1]  = r_s1_item.cool_1;
    assign cool[2]  = r_s1_item.cool_2;
    assign cool[3]  = r_s1_item.cool_3;
    assign cool[4]  = r_s1_item.cool_4;
    assign cool[5]  = r_s1_item.cool_5;
    assign cool[6]  = r_s1_item.cool_6;
    assign cool[7]  = r_s1_item.cool_7;

    always_comb begin
        logic [fhc_pkg::CELL_W:0] sum;
        for (int y = 0; y < fhc_pkg::HEIGHT; y++) begin
            if (cur_heat[y] > fhc_pkg::CELL_W'(cool[y])) begin
                cooled[y] = cur_heat[y] - fhc_pkg::CELL_W'(cool[y]);
            end else begin
                cooled[y] = '0;
            end
        end
        n_heat[0] = r_s1_item.spark ? r_s1_item.spark_heat : cooled[0];
        n_heat[1] = cooled[0];
        for (int y = 2; y < fhc_pkg::HEIGHT; y++) begin
            sum       = {1'b0, cooled[y-1]} + {1'b0, cooled[y-2]};
            n_heat[y] = sum[fhc_pkg::CELL_W:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            r_s2_col  <= r_s1_col;
            r_s2_heat <= n_heat;
        end
    end

    // stage 3: shade, top row first
    for (genvar h = 0; h < fhc_pkg::HEIGHT; h++) begin : g_shade
        fhc_shade u_shade (
            .i_heat  (r_s2_heat[h]),
            .i_pal   (r_pal),
            .o_color (color[h])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (s3_en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_en) begin
            r_s3_out.out_column <= r_s2_col;
            r_s3_out.pixel_row0 <= color[7];
            r_s3_out.pixel_row1 <= color[6];
            r_s3_out.pixel_row2 <= color[5];
            r_s3_out.pixel_row3 <= color[4];
            r_s3_out.pixel_row4 <= color[3];
            r_s3_out.pixel_row5 <= color[2];
            r_s3_out.pixel_row6 <= color[1];
            r_s3_out.pixel_row7 <= color[0];
        end
    end

    assign o_out.valid = r_s3_v;
    assign o_out.data  = r_s3_out;

endmodule

`default_nettype wire

FILE: hdl/fhc_shade.sv
// Maps one heat cell through the three thresholds to a palette color or black.
// Depends on fhc_pkg.
`default_nettype none

module fhc_shade (
    input  var fhc_pkg::t_heat    i_heat,
    input  var fhc_pkg::t_palette i_pal,
    output fhc_pkg::t_color       o_color
);

    always_comb begin
        if (i_heat > i_pal.thr_hot) begin
            o_color = i_pal.col_hot;
        end else if (i_heat > i_pal.thr_warm) begin
            o_color = i_pal.col_warm;
        end else if (i_heat > i_pal.thr_ember) begin
            o_color = i_pal.col_ember;
        end else begin
            o_color = fhc_pkg::BLACK;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/fhc_checker.sv
// Port-level checks for the fire heat column block, bound to the top level.
// Depends on fhc_pkg and led_fire_heat_column.
`default_nettype none

module fhc_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_in_valid,
    input wire                i_in_ready,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input fhc_pkg::t_out_item i_out_data
);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output transaction changed or vanished");

    a_ready_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input blocked while output drains");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_out_ready) ##1 i_out_ready ##1 i_out_ready |=> i_out_valid)
        else $error("accepted transaction did not reach the output in three cycles");

endmodule

bind led_fire_heat_column fhc_checker u_fhc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire

FILE: bench/led_fire_heat_column_tb.sv
// Self-checking bench for led_fire_heat_column: directed table, then randomized phases.
// Predicts each pixel column from its own heat store and palette and checks it in order.
// Depends on fhc_pkg, fhc_in_if, fhc_out_if and led_fire_heat_column.
`timescale 1ns / 1ps

module led_fire_heat_column_tb;

    localparam int COLUMNS     = 8;
    localparam int PIPE_LAT    = 3;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 190;
    localparam int MAX_PRINTS  = 50;

    localparam logic [fhc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [fhc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        fhc_pkg::t_in_item  item;
        bit                 typed;
        fhc_pkg::t_out_item want;
    } t_fire_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [fhc_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [fhc_pkg::CFG_DATA_W-1:0] i_cfg_data;

    fhc_in_if  in_ch ();
    fhc_out_if out_ch ();

    led_fire_heat_column #(
        .COLUMNS (COLUMNS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    fhc_pkg::t_heat_col  heat_cols [COLUMNS];
    fhc_pkg::t_palette   pal;
    fhc_pkg::t_out_item  pixel_q [$];
    t_fire_row           fire_rows [$];
    bit                  drv_typed;
    fhc_pkg::t_out_item  drv_want;
    bit                  idle_on;
    bit                  hold_req;
    int                  mismatches;
    int                  quiet_cycles;
    logic [2:0]          last_col;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic fhc_pkg::t_color shade(input fhc_pkg::t_heat h);
        if (h > pal.thr_hot) return pal.col_hot;
        if (h > pal.thr_warm) return pal.col_warm;
        if (h > pal.thr_ember) return pal.col_ember;
        return fhc_pkg::BLACK;
    endfunction

    function automatic fhc_pkg::t_out_item advance_fire(input fhc_pkg::t_in_item it);
        logic [fhc_pkg::COOL_W-1:0] cool [fhc_pkg::HEIGHT];
        fhc_pkg::t_heat             cooled [fhc_pkg::HEIGHT];
        logic [fhc_pkg::CELL_W:0]   pair_sum;
        fhc_pkg::t_heat_col         cells;
        fhc_pkg::t_out_item         res;
        int                         col;
        cool[0] = it.cool_0;
        cool[1] = it.cool_1;
        cool[2] = it.cool_2;
        cool[3] = it.cool_3;
        cool[4] = it.cool_4;
        cool[5] = it.cool_5;
        cool[6] = it.cool_6;
        cool[7] = it.cool_7;
        col = int'(it.column) % COLUMNS;
        cells = heat_cols[col];
        for (int y = 0; y < fhc_pkg::HEIGHT; y++) begin
            cooled[y] = (cells[y] > fhc_pkg::CELL_W'(cool[y]))
                      ? fhc_pkg::t_heat'(cells[y] - fhc_pkg::CELL_W'(cool[y])) : '0;
        end
        cells[0] = cooled[0];
        cells[1] = cooled[0];
        for (int y = 2; y < fhc_pkg::HEIGHT; y++) begin
            pair_sum = {1'b0, cooled[y-1]} + {1'b0, cooled[y-2]};
            cells[y] = pair_sum[fhc_pkg::CELL_W:1];
        end
        if (it.spark) begin
            cells[0] = it.spark_heat;
        end
        heat_cols[col] = cells;
        res.out_column = col[fhc_pkg::COL_IN_W-1:0];
        res.pixel_row0 = shade(cells[7]);
        res.pixel_row1 = shade(cells[6]);
        res.pixel_row2 = shade(cells[5]);
        res.pixel_row3 = shade(cells[4]);
        res.pixel_row4 = shade(cells[3]);
        res.pixel_row5 = shade(cells[2]);
        res.pixel_row6 = shade(cells[1]);
        res.pixel_row7 = shade(cells[0]);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTS) begin
            $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    task automatic check_pixels(input fhc_pkg::t_out_item got,
                                input fhc_pkg::t_out_item want);
        logic [8*fhc_pkg::COLOR_W-1:0] got_rows;
        logic [8*fhc_pkg::COLOR_W-1:0] want_rows;
        got_rows  = got[8*fhc_pkg::COLOR_W-1:0];
        want_rows = want[8*fhc_pkg::COLOR_W-1:0];
        if (got.out_column !== want.out_column) begin
            report_mismatch("out_column", 32'(got.out_column), 32'(want.out_column));
        end
        for (int r = 0; r < 8; r++) begin
            if (got_rows[(7-r)*fhc_pkg::COLOR_W +: fhc_pkg::COLOR_W] !==
                want_rows[(7-r)*fhc_pkg::COLOR_W +: fhc_pkg::COLOR_W]) begin
                report_mismatch($sformatf("pixel_row%0d col %0d", r, want.out_column),
                                32'(got_rows[(7-r)*fhc_pkg::COLOR_W +: fhc_pkg::COLOR_W]),
                                32'(want_rows[(7-r)*fhc_pkg::COLOR_W +: fhc_pkg::COLOR_W]));
            end
        end
    endtask

    // Check results first, then predict the transaction accepted on the same edge.
    always @(posedge i_clk) begin : monitor
        fhc_pkg::t_out_item want;
        fhc_pkg::t_out_item pred;
        bit                 moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                if (pixel_q.size() == 0) begin
                    report_mismatch("pixel column with none pending",
                                    32'(out_ch.data.out_column), 32'd0);
                end else begin
                    want = pixel_q.pop_front();
                    check_pixels(out_ch.data, want);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                moved = 1'b1;
                pred = advance_fire(in_ch.data);
                pixel_q.push_back(drv_typed ? drv_want : pred);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("led_fire_heat_column_tb: FAIL");
                $finish;
            end
        end
    end

    // Output side: random stall bursts, one long hold-off on request.
    initial begin
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge i_clk);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    task automatic send_item(input fhc_pkg::t_in_item it, input bit typed,
                             input fhc_pkg::t_out_item want);
        in_ch.valid = 1'b1;
        in_ch.data  = it;
        drv_typed   = typed;
        drv_want    = want;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (pixel_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [fhc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fhc_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        case (idx)
            fhc_pkg::CFG_HOT_THR:   pal.thr_hot   = val[fhc_pkg::CELL_W-1:0];
            fhc_pkg::CFG_WARM_THR:  pal.thr_warm  = val[fhc_pkg::CELL_W-1:0];
            fhc_pkg::CFG_EMBER_THR: pal.thr_ember = val[fhc_pkg::CELL_W-1:0];
            fhc_pkg::CFG_HOT_COL:   pal.col_hot   = val;
            fhc_pkg::CFG_WARM_COL:  pal.col_warm  = val;
            fhc_pkg::CFG_EMBER_COL: pal.col_ember = val;
            default: ;
        endcase
    endtask

    task automatic program_palette(input fhc_pkg::t_heat hot_t, input fhc_pkg::t_heat warm_t,
                                   input fhc_pkg::t_heat ember_t,
                                   input fhc_pkg::t_color hot_c,
                                   input fhc_pkg::t_color warm_c,
                                   input fhc_pkg::t_color ember_c);
        write_reg(fhc_pkg::CFG_HOT_THR, {16'd0, hot_t});
        write_reg(fhc_pkg::CFG_WARM_THR, {16'd0, warm_t});
        write_reg(fhc_pkg::CFG_EMBER_THR, {16'd0, ember_t});
        write_reg(fhc_pkg::CFG_HOT_COL, hot_c);
        write_reg(fhc_pkg::CFG_WARM_COL, warm_c);
        write_reg(fhc_pkg::CFG_EMBER_COL, ember_c);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, fhc_pkg::t_color'($urandom_range(0, 24'hFFFFFF)));
        i_cfg_we = 1'b0;
    endtask

    function automatic fhc_pkg::t_in_item make_update(input logic [2:0] col,
                                                      input logic [6:0] cool_lo,
                                                      input logic [6:0] cool_hi,
                                                      input logic spark,
                                                      input fhc_pkg::t_heat heat);
        fhc_pkg::t_in_item it;
        it.column     = col;
        it.cool_0     = cool_lo;
        it.cool_1     = cool_lo;
        it.cool_2     = cool_lo;
        it.cool_3     = cool_lo;
        it.cool_4     = cool_hi;
        it.cool_5     = cool_hi;
        it.cool_6     = cool_hi;
        it.cool_7     = cool_hi;
        it.spark      = spark;
        it.spark_heat = heat;
        return it;
    endfunction

    function automatic fhc_pkg::t_out_item lone_bottom(input logic [2:0] col,
                                                       input fhc_pkg::t_color bottom);
        fhc_pkg::t_out_item res;
        res = '0;
        res.out_column = col;
        res.pixel_row7 = bottom;
        return res;
    endfunction

    task automatic add_row(input fhc_pkg::t_in_item it, input bit typed,
                           input fhc_pkg::t_out_item want);
        t_fire_row row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        fire_rows.push_back(row);
    endtask

    function automatic logic [fhc_pkg::COOL_W-1:0] pick_cool();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return fhc_pkg::COOL_W'($urandom_range(0, 8));
        if (r < 18) return fhc_pkg::COOL_W'($urandom_range(0, 64));
        return fhc_pkg::COOL_W'($urandom_range(0, 127));
    endfunction

    // Favor repeats of the last column so the write-back bypass gets exercised.
    function automatic fhc_pkg::t_in_item random_update();
        fhc_pkg::t_in_item it;
        it.column     = ($urandom_range(0, 3) == 0) ? last_col : 3'($urandom_range(0, 7));
        it.cool_0     = pick_cool();
        it.cool_1     = pick_cool();
        it.cool_2     = pick_cool();
        it.cool_3     = pick_cool();
        it.cool_4     = pick_cool();
        it.cool_5     = pick_cool();
        it.cool_6     = pick_cool();
        it.cool_7     = pick_cool();
        it.spark      = 1'($urandom_range(0, 1));
        it.spark_heat = ($urandom_range(0, 9) == 0)
                      ? fhc_pkg::t_heat'($urandom_range(0, 255))
                      : fhc_pkg::t_heat'($urandom_range(160, 254));
        last_col      = it.column;
        return it;
    endfunction

    initial begin : stimulus
        fhc_pkg::t_out_item none;
        none          = '0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = fhc_pkg::CFG_HOT_THR;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.data    = '0;
        drv_typed     = 1'b0;
        drv_want      = '0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        mismatches    = 0;
        quiet_cycles  = 0;
        last_col      = '0;
        for (int c = 0; c < COLUMNS; c++) heat_cols[c] = '0;
        pal.thr_hot   = fhc_pkg::RST_HOT_THR;
        pal.thr_warm  = fhc_pkg::RST_WARM_THR;
        pal.thr_ember = fhc_pkg::RST_EMBER_THR;
        pal.col_hot   = fhc_pkg::RST_HOT_COL;
        pal.col_warm  = fhc_pkg::RST_WARM_COL;
        pal.col_ember = fhc_pkg::RST_EMBER_COL;

        add_row(make_update(0, 0, 0, 1, 254), 1, lone_bottom(0, fhc_pkg::RST_HOT_COL));
        add_row(make_update(0, 0, 0, 0, 0), 0, none);
        add_row(make_update(0, 0, 0, 0, 0), 0, none);
        add_row(make_update(0, 64, 64, 1, 181), 0, none);
        add_row(make_update(0, 127, 127, 0, 0), 0, none);
        add_row(make_update(0, 127, 127, 0, 0), 1, lone_bottom(0, fhc_pkg::BLACK));
        add_row(make_update(7, 0, 0, 1, 255), 1, lone_bottom(7, fhc_pkg::RST_HOT_COL));
        add_row(make_update(7, 5, 64, 1, 160), 0, none);
        add_row(make_update(7, 1, 2, 0, 0), 0, none);
        add_row(make_update(3, 0, 0, 1, 0), 1, lone_bottom(3, fhc_pkg::BLACK));
        add_row(make_update(3, 0, 0, 1, 61), 1, lone_bottom(3, fhc_pkg::RST_EMBER_COL));
        add_row(make_update(3, 0, 0, 1, 121), 0, none);
        add_row(make_update(5, 127, 0, 1, 180), 1, lone_bottom(5, fhc_pkg::RST_WARM_COL));
        add_row(make_update(6, 0, 0, 1, 120), 1, lone_bottom(6, fhc_pkg::RST_EMBER_COL));
        add_row(make_update(4, 0, 0, 1, 60), 1, lone_bottom(4, fhc_pkg::BLACK));
        add_row(make_update(4, 0, 0, 1, 61), 0, none);
        add_row(make_update(2, 0, 0, 1, 200), 0, none);
        add_row(make_update(2, 3, 9, 0, 0), 0, none);
        add_row(make_update(2, 64, 0, 1, 170), 0, none);
        add_row(make_update(2, 0, 127, 0, 0), 0, none);
        add_row(make_update(1, 0, 0, 1, 233), 0, none);
        add_row(make_update(1, 0, 0, 1, 233), 0, none);
        add_row(make_update(1, 10, 20, 1, 254), 0, none);

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (fire_rows[i]) begin
            send_item(fire_rows[i].item, fire_rows[i].typed, fire_rows[i].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            idle_on = (ph == NUM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            case (ph)
                0: ;
                // thresholds out of order: warm decides for any nonzero heat
                1: program_palette(8'd255, 8'd0, 8'd200, 24'hFFFFFF, 24'h000000, 24'h123456);
                2: program_palette(8'd0, 8'd0, 8'd0,
                                   fhc_pkg::t_color'($urandom_range(0, 24'hFFFFFF)),
                                   fhc_pkg::t_color'($urandom_range(0, 24'hFFFFFF)),
                                   fhc_pkg::t_color'($urandom_range(0, 24'hFFFFFF)));
                3: program_palette(8'd255, 8'd255, 8'd255, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
                4: program_palette(8'd40, 8'd200, 8'd100, 24'h00FF00, 24'h0000FF, 24'hFF0000);
                7: program_palette(fhc_pkg::RST_HOT_THR, fhc_pkg::RST_WARM_THR,
                                   fhc_pkg::RST_EMBER_THR, fhc_pkg::RST_HOT_COL,
                                   fhc_pkg::RST_WARM_COL, fhc_pkg::RST_EMBER_COL);
                default: program_palette(fhc_pkg::t_heat'($urandom_range(0, 255)),
                                         fhc_pkg::t_heat'($urandom_range(0, 255)),
                                         fhc_pkg::t_heat'($urandom_range(0, 255)),
                                         fhc_pkg::t_color'($urandom_range(0, 24'hFFFFFF)),
                                         fhc_pkg::t_color'($urandom_range(0, 24'hFFFFFF)),
                                         fhc_pkg::t_color'($urandom_range(0, 24'hFFFFFF)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold the output long enough to back up the input
                if (ph == 2 && n == 10) hold_req = 1'b1;
                // let everything in flight come out before going on
                if (ph == 5 && n == PHASE_ITEMS / 2) wait_drained();
                send_item(random_update(), 1'b0, none);
            end
        end

        in_ch.valid = 1'b0;
        while (pixel_q.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 5) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("led_fire_heat_column_tb: PASS");
        end else begin
            $display("led_fire_heat_column_tb: FAIL");
        end
        $finish;
    end

endmodule
